// File: hw/rtl/assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mrt_pkg.sv
package mrt_pkg;

    localparam int ROUTE_ENTRIES = 16;
    localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    // operation codes
    localparam logic [1:0] MODE_LEARN  = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W         = 1;
    localparam int         CFG_DATA_W        = 32;
    localparam logic       CFG_OWN_NODE_ID   = 1'b0;
    localparam logic       CFG_ROUTE_TIMEOUT = 1'b1;
    localparam logic [31:0] TIMEOUT_RESET    = 32'd60000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  destination;
        logic [7:0]  via_in;
        logic [7:0]  hops;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] via;
    } res_item_t;

    typedef struct packed {
        logic [7:0]  own_node_id;
        logic [31:0] route_timeout_ms;
    } mrt_cfg_t;

    // one table row as held in the RAM
    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  hop;
        logic [31:0] seen;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        entry_t             wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

endpackage

// File: hw/rtl/mrt_ram.sv
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/mrt_engine.sv
`include "assert_macros.svh"

module mrt_engine import mrt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  mrt_cfg_t  cfg,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      done,
    output res_item_t result,
    output mem_req_t  mem_req,
    input  entry_t    rd_entry
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

    state_t                   state_reg, state_next;
    in_item_t                 item_reg, item_next;
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [ROUTE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     match_hit_reg, match_hit_next;
    logic [IDX_W-1:0]         match_idx_reg, match_idx_next;
    logic                     match_aged_reg, match_aged_next;
    logic [7:0]               match_hop_reg, match_hop_next;
    logic                     free_hit_reg, free_hit_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]         min_idx_reg, min_idx_next;
    logic [31:0]              min_seen_reg, min_seen_next;
    logic                     done_reg, done_next;
    res_item_t                result_reg, result_next;

    logic             cur_valid;
    logic             cur_match;
    logic             cur_aged;
    logic             learn_ok;
    logic [IDX_W-1:0] target_idx;

    // age test on the row coming out of the RAM: wrapping subtract, then compare
    assign cur_valid = valid_reg[rd_idx_reg];
    assign cur_match = cur_valid && (rd_entry.dest == item_reg.destination);
    assign cur_aged  = (item_reg.now_ms - rd_entry.seen) > cfg.route_timeout_ms;

    assign learn_ok = (item_reg.mode == MODE_LEARN)
                   && (item_reg.destination != cfg.own_node_id)
                   && (item_reg.via_in != cfg.own_node_id)
                   && (item_reg.hops != 8'd0);

    // reuse the route, else a free slot, else the oldest row
    assign target_idx = match_hit_reg ? match_idx_reg
                      : (free_hit_reg ? free_idx_reg : min_idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        valid_next      = valid_reg;
        match_hit_next  = match_hit_reg;
        match_idx_next  = match_idx_reg;
        match_aged_next = match_aged_reg;
        match_hop_next  = match_hop_reg;
        free_hit_next   = free_hit_reg;
        free_idx_next   = free_idx_reg;
        min_idx_next    = min_idx_reg;
        min_seen_next   = min_seen_reg;
        done_next       = 1'b0;
        result_next     = result_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = target_idx;
        mem_req.wdata = '{dest: item_reg.destination, hop: item_reg.via_in,
                          seen: item_reg.now_ms};
        mem_req.re    = 1'b0;
        mem_req.raddr = cnt_reg;

        // row returned from the read issued last cycle
        if (rd_pend_reg)
        begin
            if (cur_match && !match_hit_reg)
            begin
                match_hit_next  = 1'b1;
                match_idx_next  = rd_idx_reg;
                match_aged_next = cur_aged;
                match_hop_next  = rd_entry.hop;
            end
            if (!cur_valid && !free_hit_reg)
            begin
                free_hit_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            // strict less-than keeps the lowest index on ties
            if ((rd_idx_reg == '0) || (rd_entry.seen < min_seen_reg))
            begin
                min_idx_next  = rd_idx_reg;
                min_seen_next = rd_entry.seen;
            end
            if ((item_reg.mode == MODE_EXPIRE) && cur_valid && cur_aged)
            begin
                valid_next[rd_idx_reg] = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next      = item;
                    cnt_next       = '0;
                    match_hit_next = 1'b0;
                    free_hit_next  = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_req.re   = 1'b1;
                rd_pend_next = 1'b1;
                rd_idx_next  = cnt_reg;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                result_next = '{found: 1'b0, via: 8'd0};
                if (learn_ok)
                begin
                    mem_req.we             = 1'b1;
                    valid_next[target_idx] = 1'b1;
                end
                if ((item_reg.mode == MODE_LOOKUP) && match_hit_reg)
                begin
                    if (match_aged_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        result_next = '{found: 1'b1, via: match_hop_reg};
                    end
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= rd_idx_next;
        match_hit_reg  <= match_hit_next;
        match_idx_reg  <= match_idx_next;
        match_aged_reg <= match_aged_next;
        match_hop_reg  <= match_hop_next;
        free_hit_reg   <= free_hit_next;
        free_idx_reg   <= free_idx_next;
        min_idx_reg    <= min_idx_next;
        min_seen_reg   <= min_seen_next;
        result_reg     <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_NEXT(a_done_single, done_reg, !done_reg, "done strobe held over two cycles")
    `ASSERT_IMPL(a_no_rw_clash, mem_req.we, !mem_req.re, "RAM read and write together")
    `ASSERT_IMPL(a_found_lookup, done_reg && result_reg.found,
                 item_reg.mode == MODE_LOOKUP, "found reported for non-lookup")
    `ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer accepted but not busy")

endmodule

// File: hw/rtl/mesh_route_table.sv
// Mesh route table: ROUTE_ENTRIES rows of destination, next hop and last-seen
// time, held in one single-port-read RAM, with valid bits in flops that reset
// clears. Raise start with an item while busy is low; the transfer is taken on
// that edge. Every item walks the whole table one row per cycle through the
// RAM read port: after the accepting edge busy stays high through the scan
// (one read per row), a drain state for the last read and a finish state
// that decides and writes back, and done marks the result in the cycle after
// the finish state. busy is already low while done is high, so the next item
// can be taken on the same edge as the result, but not before the last item's
// result. The result is shown for exactly one cycle with done; the receiver
// cannot stall it, so it must sample on that edge. Every item, learn and
// expire too, gives one result. Configuration writes are taken whenever
// cfg_we is high and must only happen while the block is idle.
module mesh_route_table import mrt_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // item transfer
    input  logic                  start,
    input  in_item_t              item,
    output logic                  busy,
    // result transfer
    output logic                  done,
    output res_item_t             result,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mrt_cfg_t cfg_reg, cfg_next;
    mem_req_t mem_req;
    entry_t   rd_entry;
    logic [ENTRY_W-1:0] rd_raw;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_NODE_ID:   cfg_next.own_node_id      = cfg_data[7:0];
                CFG_ROUTE_TIMEOUT: cfg_next.route_timeout_ms = cfg_data[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{own_node_id: 8'd0, route_timeout_ms: TIMEOUT_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // table rows; contents are undefined until learned, guarded by valid bits
    mrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROUTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);

    // scan, decide and write-back sequencer
    mrt_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .mem_req  (mem_req),
        .rd_entry (rd_entry)
    );

endmodule
